### src/rc_frame_receiver_crc8_top_defines.svh
// Assertion macros for the frame receiver top level.
`ifndef RC_FRAME_RECEIVER_CRC8_TOP_DEFINES_SVH
`define RC_FRAME_RECEIVER_CRC8_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCFR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RCFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed in the following cycle");

`endif

### src/rcfr_pkg.sv
// Package with the shared types, codes and CRC function of the frame receiver.
`timescale 1ns / 1ps
package rcfr_pkg;

  localparam int NUM_CHANNELS_DEFAULT = 24;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Configuration register indexes.
  localparam logic [7:0] CFG_HEADER       = 8'd0;
  localparam logic [7:0] CFG_FOOTER       = 8'd1;
  localparam logic [7:0] CFG_CHANNELS_CMD = 8'd2;
  localparam logic [7:0] CFG_CRC_ENFORCE  = 8'd3;

  // Result kinds.
  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_cmd;
    logic take_len;
    logic take_data;
    logic take_crc;
    logic load_status;
    logic ch_start;
    logic ch_load;
  } rcfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_match;
    logic len_zero;
    logic data_done;
    logic emit_channels;
    logic out_busy;
    logic ch_last;
  } rcfr_stat_t;

  // CRC-8, MSB first, one byte.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### src/rcfr_datapath.sv
// Datapath of the frame receiver: frame registers, CRC, payload store and result register.
`timescale 1ns / 1ps
module rcfr_datapath #(
  parameter int NUM_CHANNELS = rcfr_pkg::NUM_CHANNELS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [7:0]          rx_byte,
  input  rcfr_pkg::rcfr_cmd_t cmd,
  output rcfr_pkg::rcfr_stat_t stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                kind,
  output logic [4:0]          channel_index,
  output logic [15:0]         channel_value,
  output logic [15:0]         previous_value,
  output logic [7:0]          frame_command,
  output logic                crc_ok,
  output logic                footer_ok,
  output logic                last
);

  localparam int STORE_DEPTH = 2 * NUM_CHANNELS;
  localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  logic [7:0] header_value;
  logic [7:0] footer_value;
  logic [7:0] channels_command;
  logic       crc_enforce;

  logic [7:0] frame_cmd;
  logic [7:0] payload_length;
  logic [7:0] byte_count;
  logic [7:0] running_crc;
  logic [7:0] received_crc;

  logic [7:0]  store [STORE_DEPTH];
  logic [7:0]  rd_lo;
  logic [7:0]  rd_hi;
  logic [15:0] prev [NUM_CHANNELS];

  logic [CH_W-1:0] ch_idx;
  logic [CH_W:0]   lo_pos;
  logic [CH_W:0]   hi_pos;
  logic [7:0]      lo_byte;
  logic [7:0]      hi_byte;
  logic [15:0]     new_value;
  logic            cok;
  logic            fok;

  assign lo_pos = {ch_idx, 1'b0};
  assign hi_pos = {ch_idx, 1'b1};

  // Bytes past the received length read as zero.
  assign lo_byte   = (8'(lo_pos) < payload_length) ? rd_lo : 8'd0;
  assign hi_byte   = (8'(hi_pos) < payload_length) ? rd_hi : 8'd0;
  assign new_value = {hi_byte, lo_byte};

  assign cok = (running_crc == received_crc);
  assign fok = (rx_byte == footer_value);

  always_comb begin
    stat.hdr_match     = (rx_byte == header_value);
    stat.len_zero      = (rx_byte == 8'd0);
    stat.data_done     = (8'(byte_count + 8'd1) == payload_length);
    stat.emit_channels = fok && (frame_cmd == channels_command) && (!crc_enforce || cok);
    stat.out_busy      = out_valid && !out_ready;
    stat.ch_last       = (ch_idx == CH_W'(NUM_CHANNELS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value     <= 8'd0;
      footer_value     <= 8'd0;
      channels_command <= 8'd0;
      crc_enforce      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rcfr_pkg::CFG_HEADER:       header_value     <= cfg_data;
        rcfr_pkg::CFG_FOOTER:       footer_value     <= cfg_data;
        rcfr_pkg::CFG_CHANNELS_CMD: channels_command <= cfg_data;
        rcfr_pkg::CFG_CRC_ENFORCE:  crc_enforce      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cmd      <= 8'd0;
      payload_length <= 8'd0;
      byte_count     <= 8'd0;
      running_crc    <= rcfr_pkg::CRC_INIT;
      received_crc   <= 8'd0;
    end else begin
      if (cmd.take_cmd) begin
        frame_cmd <= rx_byte;
      end
      if (cmd.take_len) begin
        payload_length <= rx_byte;
        byte_count     <= 8'd0;
        running_crc    <= rcfr_pkg::CRC_INIT;
      end
      if (cmd.take_data) begin
        byte_count  <= 8'(byte_count + 8'd1);
        running_crc <= rcfr_pkg::crc8_update(running_crc, rx_byte);
      end
      if (cmd.take_crc) begin
        received_crc <= rx_byte;
      end
    end
  end

  // Payload store: only the first bytes that can carry channels are kept.
  always_ff @(posedge clk) begin
    if (cmd.take_data && (byte_count < 8'(STORE_DEPTH))) begin
      store[byte_count[ADDR_W-1:0]] <= rx_byte;
    end
    rd_lo <= store[lo_pos[ADDR_W-1:0]];
    rd_hi <= store[hi_pos[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_idx <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prev[i] <= 16'd0;
      end
    end else if (cmd.ch_start) begin
      ch_idx <= '0;
    end else if (cmd.ch_load) begin
      prev[ch_idx] <= new_value;
      ch_idx       <= CH_W'(ch_idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_status || cmd.ch_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      kind           <= rcfr_pkg::KIND_STATUS;
      channel_index  <= 5'd0;
      channel_value  <= 16'd0;
      previous_value <= 16'd0;
      frame_command  <= frame_cmd;
      crc_ok         <= cok;
      footer_ok      <= fok;
      last           <= 1'b1;
    end else if (cmd.ch_load) begin
      kind           <= rcfr_pkg::KIND_CHANNEL;
      channel_index  <= 5'(ch_idx);
      channel_value  <= new_value;
      previous_value <= prev[ch_idx];
      frame_command  <= frame_cmd;
      crc_ok         <= cok;
      footer_ok      <= 1'b1;
      last           <= stat.ch_last;
    end
  end

endmodule

### src/rcfr_ctrl.sv
// Controller of the frame receiver: frame phase tracking and the channel burst sequencer.
`timescale 1ns / 1ps
module rcfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rcfr_pkg::rcfr_stat_t stat,
  output rcfr_pkg::rcfr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_HUNT,
    S_CMD,
    S_LEN,
    S_DATA,
    S_CRC,
    S_FOOT,
    S_CH_READ,
    S_CH_LOAD
  } state_t;

  state_t state;
  logic   in_acc;

  // A footer beat needs the result register free; other bytes never wait on it.
  always_comb begin
    case (state)
      S_HUNT, S_CMD, S_LEN, S_DATA, S_CRC: in_ready = 1'b1;
      S_FOOT:  in_ready = !stat.out_busy;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  always_comb begin
    cmd.take_cmd    = in_acc && (state == S_CMD);
    cmd.take_len    = in_acc && (state == S_LEN);
    cmd.take_data   = in_acc && (state == S_DATA);
    cmd.take_crc    = in_acc && (state == S_CRC);
    cmd.load_status = in_acc && (state == S_FOOT) && !stat.emit_channels;
    cmd.ch_start    = in_acc && (state == S_FOOT) && stat.emit_channels;
    cmd.ch_load     = (state == S_CH_LOAD) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      case (state)
        S_HUNT: begin
          if (in_acc && stat.hdr_match) state <= S_CMD;
        end
        S_CMD: begin
          if (in_acc) state <= S_LEN;
        end
        S_LEN: begin
          if (in_acc) state <= stat.len_zero ? S_CRC : S_DATA;
        end
        S_DATA: begin
          if (in_acc && stat.data_done) state <= S_CRC;
        end
        S_CRC: begin
          if (in_acc) state <= S_FOOT;
        end
        S_FOOT: begin
          if (in_acc) state <= stat.emit_channels ? S_CH_READ : S_HUNT;
        end
        S_CH_READ: begin
          state <= S_CH_LOAD;
        end
        S_CH_LOAD: begin
          if (!stat.out_busy) state <= stat.ch_last ? S_HUNT : S_CH_READ;
        end
        default: begin
          state <= S_HUNT;
        end
      endcase
    end
  end

endmodule

### src/rc_frame_receiver_crc8_top.sv
// Top level of the remote-control frame receiver with CRC-8 payload check.
//
// The block takes one received byte per cycle while it parses a frame (header, command,
// length, payload, CRC, footer), except where a footer byte waits, as below. A frame ending
// in a matching footer and the channels command, and a matching CRC if enforcement is on,
// starts a burst of NUM_CHANNELS channel results, each channel in a read and a load state
// as its pair of payload bytes comes through the registered read of the payload store; no
// byte is taken during the burst, which an output stall holds. Any other frame gives one
// status result, and bytes keep flowing while it waits, except that the next footer beat
// waits until the result register is free. Configuration writes are taken on every cycle.
`timescale 1ns / 1ps
`include "rc_frame_receiver_crc8_top_defines.svh"
module rc_frame_receiver_crc8_top #(
  parameter int NUM_CHANNELS = rcfr_pkg::NUM_CHANNELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [4:0]  channel_index,
  output logic [15:0] channel_value,
  output logic [15:0] previous_value,
  output logic [7:0]  frame_command,
  output logic        crc_ok,
  output logic        footer_ok,
  output logic        last
);

  rcfr_pkg::rcfr_cmd_t  cmd;
  rcfr_pkg::rcfr_stat_t stat;

  assign cfg_ready = 1'b1;

  rcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcfr_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .kind           (kind),
    .channel_index  (channel_index),
    .channel_value  (channel_value),
    .previous_value (previous_value),
    .frame_command  (frame_command),
    .crc_ok         (crc_ok),
    .footer_ok      (footer_ok),
    .last           (last)
  );

  // A result beat is never written over one that is still waiting.
  `RCFR_ASSERT_SAME(a_no_overwrite, cmd.load_status || cmd.ch_load, !(out_valid && !out_ready))
  // A status frame leaves exactly one final status beat.
  `RCFR_ASSERT_NEXT(a_status_beat, cmd.load_status, out_valid && kind && last)
  // The final channel of a burst is marked as the last beat.
  `RCFR_ASSERT_NEXT(a_burst_end, cmd.ch_load && stat.ch_last, out_valid && !kind && last)
  // No byte is taken while the channel burst runs.
  `RCFR_ASSERT_SAME(a_no_byte_in_burst, cmd.ch_load, !(in_valid && in_ready))

endmodule

### dv/tb.sv
// Testbench for the frame receiver: framed byte traffic checked beat by beat against a predictor.
`timescale 1ns / 1ps

localparam int NUM_CH = rcfr_pkg::NUM_CHANNELS_DEFAULT;
localparam int STORE_BYTES = 2 * NUM_CH;

typedef struct packed {
  logic        kind;
  logic [4:0]  chan;
  logic [15:0] value;
  logic [15:0] prev;
  logic [7:0]  cmd;
  logic        crc_ok;
  logic        footer_ok;
  logic        last;
} rcfr_result_t;

typedef enum logic [2:0] {
  P_HUNT,
  P_CMD,
  P_LEN,
  P_DATA,
  P_CRC,
  P_FOOTER
} parse_phase_t;

function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
  logic [7:0] c;
  c = crc ^ b;
  for (int k = 0; k < 8; k++) begin
    if (c[7]) begin
      c = {c[6:0], 1'b0} ^ rcfr_pkg::CRC_POLY;
    end else begin
      c = {c[6:0], 1'b0};
    end
  end
  return c;
endfunction

class frame_scoreboard;
  logic [7:0]   header_value;
  logic [7:0]   footer_value;
  logic [7:0]   channels_cmd;
  logic         crc_enforce;
  parse_phase_t phase;
  logic [7:0]   cmd_byte;
  logic [7:0]   length;
  logic [7:0]   count;
  logic [7:0]   crc_run;
  logic [7:0]   crc_rx;
  logic [7:0]   payload [STORE_BYTES];
  logic [15:0]  prev_ch [NUM_CH];
  rcfr_result_t expected_q [$];
  int unsigned  errors;

  function new();
    header_value = 8'h00;
    footer_value = 8'h00;
    channels_cmd = 8'h00;
    crc_enforce  = 1'b0;
    phase        = P_HUNT;
    cmd_byte     = 8'h00;
    length       = 8'h00;
    count        = 8'h00;
    crc_run      = rcfr_pkg::CRC_INIT;
    crc_rx       = 8'h00;
    foreach (payload[i]) payload[i] = 8'h00;
    foreach (prev_ch[i]) prev_ch[i] = 16'h0000;
    errors = 0;
  endfunction

  function void write_reg(logic [7:0] idx, logic [7:0] data);
    case (idx)
      rcfr_pkg::CFG_HEADER:       header_value = data;
      rcfr_pkg::CFG_FOOTER:       footer_value = data;
      rcfr_pkg::CFG_CHANNELS_CMD: channels_cmd = data;
      rcfr_pkg::CFG_CRC_ENFORCE:  crc_enforce = data[0];
      default: ;
    endcase
  endfunction

  // Bytes beyond the declared length read as zero.
  function logic [7:0] stored(int idx);
    if (idx < int'(length) && idx < STORE_BYTES) return payload[idx];
    return 8'h00;
  endfunction

  function void note_byte(logic [7:0] b);
    rcfr_result_t r;
    logic         fok;
    logic         cok;
    logic [7:0]   lo;
    logic [7:0]   hi;
    case (phase)
      P_CMD: begin
        cmd_byte = b;
        phase = P_LEN;
      end
      P_LEN: begin
        length = b;
        count = 8'h00;
        crc_run = rcfr_pkg::CRC_INIT;
        phase = (b == 8'h00) ? P_CRC : P_DATA;
      end
      P_DATA: begin
        if (int'(count) < STORE_BYTES) payload[count] = b;
        crc_run = crc8_next(crc_run, b);
        count = count + 8'h01;
        if (count == length) phase = P_CRC;
      end
      P_CRC: begin
        crc_rx = b;
        phase = P_FOOTER;
      end
      P_FOOTER: begin
        phase = P_HUNT;
        fok = (b == footer_value);
        cok = (crc_run == crc_rx);
        if (fok && cmd_byte == channels_cmd && (!crc_enforce || cok)) begin
          for (int i = 0; i < NUM_CH; i++) begin
            lo = stored(2 * i);
            hi = stored(2 * i + 1);
            r.kind      = rcfr_pkg::KIND_CHANNEL;
            r.chan      = i[4:0];
            r.value     = {hi, lo};
            r.prev      = prev_ch[i];
            r.cmd       = cmd_byte;
            r.crc_ok    = cok;
            r.footer_ok = 1'b1;
            r.last      = (i == NUM_CH - 1);
            expected_q.push_back(r);
            prev_ch[i] = {hi, lo};
          end
        end else begin
          r.kind      = rcfr_pkg::KIND_STATUS;
          r.chan      = 5'd0;
          r.value     = 16'h0000;
          r.prev      = 16'h0000;
          r.cmd       = cmd_byte;
          r.crc_ok    = cok;
          r.footer_ok = fok;
          r.last      = 1'b1;
          expected_q.push_back(r);
        end
      end
      default: phase = (b == header_value) ? P_CMD : P_HUNT;
    endcase
  endfunction

  function string show(rcfr_result_t r);
    return $sformatf("kind=%0b ch=%0d val=%h prev=%h cmd=%h crc_ok=%0b footer_ok=%0b last=%0b",
                     r.kind, r.chan, r.value, r.prev, r.cmd, r.crc_ok, r.footer_ok, r.last);
  endfunction

  function void check_result(rcfr_result_t got);
    rcfr_result_t exp;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: got %s", show(got));
    end else begin
      exp = expected_q.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: expected %s", show(exp));
          $display("                 actual   %s", show(got));
        end
      end
    end
  endfunction
endclass

module tb;
  localparam logic [7:0] CFG_FIRST_SPARE = 8'd4;
  localparam int unsigned DRAIN_CYCLES = 2 * NUM_CH + 20;
  localparam int unsigned LONG_HOLD = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [4:0]  channel_index;
  logic [15:0] channel_value;
  logic [15:0] previous_value;
  logic [7:0]  frame_command;
  logic        crc_ok;
  logic        footer_ok;
  logic        last;

  frame_scoreboard sb;
  rcfr_result_t    got;
  logic            long_hold_req;
  logic            hold_started;
  bit              tx_calm;
  int unsigned     bytes_sent;
  int unsigned     stall_left;
  int unsigned     hold_left;
  int unsigned     rx_beats;
  int unsigned     rx_gap;

  rc_frame_receiver_crc8_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .channel_index  (channel_index),
    .channel_value  (channel_value),
    .previous_value (previous_value),
    .frame_command  (frame_command),
    .crc_ok         (crc_ok),
    .footer_ok      (footer_ok),
    .last           (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stalls per beat, a calm stretch in every 96 beats, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_started <= 1'b0;
      rx_beats <= 0;
    end else if (long_hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) out_ready <= 1'b1;
    end else if (out_ready && out_valid) begin
      rx_beats <= rx_beats + 1;
      rx_gap = ((rx_beats % 96) >= 64) ? 0 : $urandom_range(0, 4);
      out_ready <= (rx_gap == 0);
      if (rx_gap != 0) stall_left <= rx_gap - 1;
    end else if (!out_ready) begin
      if (stall_left == 0) out_ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got.kind      = kind;
      got.chan      = channel_index;
      got.value     = channel_value;
      got.prev      = previous_value;
      got.cmd       = frame_command;
      got.crc_ok    = crc_ok;
      got.footer_ok = footer_ok;
      got.last      = last;
      sb.check_result(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // The CRC is computed over the body actually sent, so a length mismatch gives a broken frame.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [7:0] body [$], input logic [7:0] crc_flip,
                            input logic [7:0] closing);
    logic [7:0] crc;
    crc = rcfr_pkg::CRC_INIT;
    send_byte(sb.header_value);
    send_byte(cmd);
    send_byte(len);
    foreach (body[i]) begin
      crc = crc8_next(crc, body[i]);
      send_byte(body[i]);
    end
    send_byte(crc ^ crc_flip);
    send_byte(closing);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [7:0] hdr, input logic [7:0] ftr,
                           input logic [7:0] cmd, input logic [7:0] enforce);
    write_reg(rcfr_pkg::CFG_HEADER, hdr);
    write_reg(rcfr_pkg::CFG_FOOTER, ftr);
    write_reg(rcfr_pkg::CFG_CHANNELS_CMD, cmd);
    write_reg(rcfr_pkg::CFG_CRC_ENFORCE, enforce);
    write_reg(8'($urandom_range(CFG_FIRST_SPARE, 8'hFF)), 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(input int unsigned n_bytes, input bit with_long);
    int unsigned start;
    int unsigned sel;
    int unsigned len;
    logic [7:0]  body [$];
    logic [7:0]  cmd;
    logic [7:0]  flip;
    logic [7:0]  closing;
    if (with_long) begin
      body.delete();
      repeat (255) body.push_back(8'($urandom_range(0, 255)));
      send_frame(sb.channels_cmd, 8'd255, body, 8'h00, sb.footer_value);
    end
    // Frames keep coming after the long one, so a held-off result side stalls the input.
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) len = $urandom_range(0, 8);
      else if (sel < 80) len = $urandom_range(9, STORE_BYTES);
      else len = $urandom_range(STORE_BYTES + 1, STORE_BYTES + 16);
      body.delete();
      repeat (len) begin
        // The header value now and then inside the payload, where it is plain data.
        if ($urandom_range(0, 9) == 0) body.push_back(sb.header_value);
        else body.push_back(8'($urandom_range(0, 255)));
      end
      cmd = ($urandom_range(0, 3) != 0) ? sb.channels_cmd : 8'($urandom_range(0, 255));
      flip = ($urandom_range(0, 5) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
      closing = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : sb.footer_value;
      if ($urandom_range(0, 19) == 0 && len > 0) begin
        if ($urandom_range(0, 1) == 0) void'(body.pop_back());
        else body.push_back(8'($urandom_range(0, 255)));
      end
      send_frame(cmd, len[7:0], body, flip, closing);
    end
    // Run the parser back to hunting so that the next register writes find it quiet.
    while (sb.phase != P_HUNT) send_byte(8'($urandom_range(0, 255)));
    tx_calm = 1'b0;
  endtask

  initial begin
    logic [7:0] body [$];
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= 8'h00;
    cfg_data <= 8'h00;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    long_hold_req <= 1'b0;
    tx_calm = 1'b0;
    bytes_sent = 0;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames with the reset settings: header, footer and channels command all zero.
    send_byte(8'h55);
    body.delete();
    send_frame(8'h00, 8'd0, body, 8'h00, 8'h00);
    body.push_back(8'hFF);
    body.push_back(8'h00);
    body.push_back(8'hAB);
    send_frame(8'h00, 8'd3, body, 8'h00, 8'h00);
    body.delete();
    body.push_back(8'h80);
    send_frame(8'h00, 8'd1, body, 8'h01, 8'h00);
    body.delete();
    send_frame(8'h07, 8'd0, body, 8'h00, 8'h5A);
    settle();

    configure(8'hFF, 8'h00, 8'hFF, 8'h01);
    random_traffic(35, 1'b0);
    settle();

    configure(8'h00, 8'hFF, 8'h00, 8'hFE);
    long_hold_req <= 1'b1;
    random_traffic(35, 1'b1);
    settle();

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(35, 1'b0);
    settle();

    configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'h01);
    random_traffic(35, 1'b0);
    settle();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
